### src/focal_plane_offset_to_sky_assert.svh
// assertion macros used by the checker file of the focal-plane-to-sky block
// no dependencies; include by bare file name inside a module that has aclk and aresetn
`ifndef FOCAL_PLANE_OFFSET_TO_SKY_ASSERT_SVH
`define FOCAL_PLANE_OFFSET_TO_SKY_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FPOS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FPOS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fpos_pkg.sv
// shared widths, cordic constants, datapath types and the q30 product helper
// no dependencies
`default_nettype none

package fpos_pkg;

    localparam int ANGLE_W = 32;
    localparam int ITERS   = 31;
    localparam int IDX_W   = 5;
    localparam int ROT_W   = 34;
    localparam int VEC_W   = 36;
    localparam int Q_W     = 32;
    localparam int SUM_W   = 34;
    localparam int SQ_W    = 62;
    localparam int ROOT_W  = 31;
    localparam int QF      = 30;
    localparam int TAG_W   = 16;
    localparam int IN_W    = 4 * ANGLE_W + TAG_W;
    localparam int OUT_W   = 2 * ANGLE_W + TAG_W;
    // input register, rotation cells, sign fixup, four product stages,
    // root cells, vectoring setup, vectoring cells
    localparam int LAT     = 1 + ITERS + 1 + 4 + ROOT_W + 1 + ITERS;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
    localparam logic signed [Q_W-1:0]   ONE_Q       = 32'sh4000_0000;

    typedef logic [ANGLE_W-1:0] angle_t;

    // atan(2^-i) in units of 2^-32 turn
    localparam angle_t ATAN_TAB [ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1
    };

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        angle_t                  z;
    } rot_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        angle_t                  z;
    } vec_t;

    typedef struct packed {
        logic [SQ_W-1:0]   rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [Q_W-1:0]   s;
        logic signed [SUM_W-1:0] num;
        logic signed [SUM_W-1:0] den;
    } args_t;

    // q30 product rounded half up, floor shift
    function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                 input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] p;
        p = a * b + (64'sd1 <<< (QF - 1));
        return p[QF+Q_W-1:QF];
    endfunction

endpackage

`default_nettype wire

### src/fpos_rot_cell.sv
// one rotation-mode cordic iteration, registered, used for sin and cos
// depends on fpos_pkg
`default_nettype none

module fpos_rot_cell
    import fpos_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] iter,
    input  wire rot_t             d_in,
    output rot_t                  d_out
);

    rot_t d_reg;
    rot_t d_next;

    always_comb begin
        if (!d_in.z[ANGLE_W-1]) begin
            d_next.x = d_in.x - (d_in.y >>> iter);
            d_next.y = d_in.y + (d_in.x >>> iter);
            d_next.z = d_in.z - ATAN_TAB[iter];
        end else begin
            d_next.x = d_in.x + (d_in.y >>> iter);
            d_next.y = d_in.y - (d_in.x >>> iter);
            d_next.z = d_in.z + ATAN_TAB[iter];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

### src/fpos_sqrt_cell.sv
// one result bit of the integer square root, registered
// depends on fpos_pkg
`default_nettype none

module fpos_sqrt_cell
    import fpos_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] bit_pos,
    input  wire sqrt_t            d_in,
    output sqrt_t                 d_out
);

    sqrt_t           d_reg;
    sqrt_t           d_next;
    logic [SQ_W-1:0] trial;

    // (r + 2^k)^2 - r^2, root only holds bits above k
    assign trial = ({{(SQ_W-ROOT_W){1'b0}}, d_in.root} << (bit_pos + 5'd1))
                 | ({{(SQ_W-1){1'b0}}, 1'b1} << {bit_pos, 1'b0});

    always_comb begin
        d_next = d_in;
        if (d_in.rem >= trial) begin
            d_next.rem  = d_in.rem - trial;
            d_next.root = d_in.root | ({{(ROOT_W-1){1'b0}}, 1'b1} << bit_pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

### src/fpos_vec_cell.sv
// one vectoring-mode cordic iteration, registered, used for atan2
// depends on fpos_pkg
`default_nettype none

module fpos_vec_cell
    import fpos_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] iter,
    input  wire vec_t             d_in,
    output vec_t                  d_out
);

    vec_t d_reg;
    vec_t d_next;

    always_comb begin
        if (!d_in.y[VEC_W-1]) begin
            d_next.x = d_in.x + (d_in.y >>> iter);
            d_next.y = d_in.y - (d_in.x >>> iter);
            d_next.z = d_in.z + ATAN_TAB[iter];
        end else begin
            d_next.x = d_in.x - (d_in.y >>> iter);
            d_next.y = d_in.y + (d_in.x >>> iter);
            d_next.z = d_in.z - ATAN_TAB[iter];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

### src/focal_plane_offset_to_sky.sv
// focal-plane offset to sky coordinates: input fold, cordic cell rows, products,
// root cells, output register with skid; depends on fpos_pkg and the three cell modules
//
// usage
//   s_axis carries one boresight sample with one detector offset per item;
//   m_axis returns that detector's sky longitude and latitude plus the tag.
//   cfg_we / cfg_wdata set coord_mode (0 local, 1 equatorial); write only
//   while no item is in flight.
//   on the way to m_axis_tvalid the input fold register loads at the
//   accepting edge, then come 31 sin/cos cells, one sign fixup, four product
//   stages, 31 square-root cells, one atan2 setup and 31 atan2 cells, then
//   the output register. one item is accepted per cycle while no item is
//   parked in the skid register, set by the cell rows which all advance together.
//   when the receiver stalls, one finished item parks in a skid register and
//   s_axis_tready drops in the next cycle; the whole pipeline then holds
//   until the skid drains, so no item is lost or repeated.
//   reset empties the pipeline and the output, and sets coord_mode to 1.
`default_nettype none

module focal_plane_offset_to_sky
    import fpos_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_wdata,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // boresight_lon, boresight_lat, offset_x, offset_y, detector_tag
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // sky_lon, sky_lat, result_tag
    output logic [OUT_W-1:0]      m_axis_tdata
);

    logic en;
    logic mode_reg;

    logic             valid_reg [LAT];
    logic [TAG_W-1:0] tag_reg   [LAT];

    // ---------------- input fold
    rot_t       rot0_reg  [4];
    logic [3:0] flip_reg  [ITERS+1];
    rot_t       rot0_next [4];
    logic [3:0] flip_next;

    always_comb begin
        logic signed [ANGLE_W-1:0] z;
        for (int a = 0; a < 4; a++) begin
            z = s_axis_tdata[a*ANGLE_W +: ANGLE_W];
            flip_next[a] = 1'b0;
            if (z > 32'sh4000_0000 || z < -32'sh4000_0000) begin
                z = (z > 0) ? z - 32'sh8000_0000 : z + 32'sh8000_0000;
                flip_next[a] = 1'b1;
            end
            rot0_next[a].x = CORDIC_GAIN;
            rot0_next[a].y = '0;
            rot0_next[a].z = z;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot0_reg    <= rot0_next;
            flip_reg[0] <= flip_next;
            for (int j = 1; j <= ITERS; j++) begin
                flip_reg[j] <= flip_reg[j-1];
            end
        end
    end

    // ---------------- sin/cos cell rows
    rot_t rot_q [4][ITERS+1];

    for (genvar a = 0; a < 4; a++) begin : g_sc
        assign rot_q[a][0] = rot0_reg[a];
        for (genvar i = 0; i < ITERS; i++) begin : g_cell
            fpos_rot_cell u_cell (
                .aclk  (aclk),
                .en    (en),
                .iter  (IDX_W'(i)),
                .d_in  (rot_q[a][i]),
                .d_out (rot_q[a][i+1])
            );
        end
    end

    // ---------------- sign fixup: sin[a], cos[a] per angle
    logic signed [Q_W-1:0] sin_reg [4];
    logic signed [Q_W-1:0] cos_reg [4];

    always_ff @(posedge aclk) begin
        logic signed [ROT_W-1:0] sv;
        logic signed [ROT_W-1:0] cv;
        if (en) begin
            for (int a = 0; a < 4; a++) begin
                sv = flip_reg[ITERS][a] ? -rot_q[a][ITERS].y : rot_q[a][ITERS].y;
                cv = flip_reg[ITERS][a] ? -rot_q[a][ITERS].x : rot_q[a][ITERS].x;
                // equatorial mode flips the sign of sin(y)
                if (a == 3 && mode_reg) begin
                    sv = -sv;
                end
                sin_reg[a] <= sv[Q_W-1:0];
                cos_reg[a] <= cv[Q_W-1:0];
            end
        end
    end

    // ---------------- products, first level
    logic signed [Q_W-1:0] cxcy_reg, sxcy_reg, sacd_reg, cacd_reg, sasd_reg, casd_reg;
    logic signed [Q_W-1:0] p1_sa_reg, p1_ca_reg, p1_sd_reg, p1_cd_reg, p1_sy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cxcy_reg  <= mulq(cos_reg[2], cos_reg[3]);
            sxcy_reg  <= mulq(sin_reg[2], cos_reg[3]);
            sacd_reg  <= mulq(sin_reg[0], cos_reg[1]);
            cacd_reg  <= mulq(cos_reg[0], cos_reg[1]);
            sasd_reg  <= mulq(sin_reg[0], sin_reg[1]);
            casd_reg  <= mulq(cos_reg[0], sin_reg[1]);
            p1_sa_reg <= sin_reg[0];
            p1_ca_reg <= cos_reg[0];
            p1_sd_reg <= sin_reg[1];
            p1_cd_reg <= cos_reg[1];
            p1_sy_reg <= sin_reg[3];
        end
    end

    // ---------------- products, second level
    logic signed [Q_W-1:0] t1_reg, t2_reg, n1_reg, n2_reg, n3_reg, d1_reg, d2_reg, d3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= mulq(p1_sd_reg, cxcy_reg);
            t2_reg <= mulq(p1_cd_reg, p1_sy_reg);
            n1_reg <= mulq(sacd_reg, cxcy_reg);
            n2_reg <= mulq(p1_ca_reg, sxcy_reg);
            n3_reg <= mulq(sasd_reg, p1_sy_reg);
            d1_reg <= mulq(cacd_reg, cxcy_reg);
            d2_reg <= mulq(p1_sa_reg, sxcy_reg);
            d3_reg <= mulq(casd_reg, p1_sy_reg);
        end
    end

    // ---------------- sums and asin argument clamp
    args_t sum_reg;

    always_ff @(posedge aclk) begin
        logic signed [SUM_W-1:0] s_full;
        if (en) begin
            s_full = SUM_W'(t1_reg) + SUM_W'(t2_reg);
            if (s_full > SUM_W'(ONE_Q)) begin
                sum_reg.s <= ONE_Q;
            end else if (s_full < -SUM_W'(ONE_Q)) begin
                sum_reg.s <= -ONE_Q;
            end else begin
                sum_reg.s <= s_full[Q_W-1:0];
            end
            sum_reg.num <= -SUM_W'(n1_reg) - SUM_W'(n2_reg) + SUM_W'(n3_reg);
            sum_reg.den <=  SUM_W'(d1_reg) - SUM_W'(d2_reg) - SUM_W'(d3_reg);
        end
    end

    // ---------------- radicand 1 - s^2
    logic [SQ_W-1:0]   rad_reg;
    args_t             args_reg [ROOT_W+1];
    logic [ROOT_W-1:0] s_abs;
    logic [SQ_W-1:0]   s_sq;

    assign s_abs = sum_reg.s[Q_W-1] ? ROOT_W'(-sum_reg.s) : sum_reg.s[ROOT_W-1:0];
    assign s_sq  = s_abs * s_abs;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg     <= (SQ_W'(1) << (2 * QF)) - s_sq;
            args_reg[0] <= sum_reg;
            for (int j = 1; j <= ROOT_W; j++) begin
                args_reg[j] <= args_reg[j-1];
            end
        end
    end

    // ---------------- square root cell row
    sqrt_t sq_q [ROOT_W+1];

    assign sq_q[0] = '{rem: rad_reg, root: '0};

    for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
        fpos_sqrt_cell u_cell (
            .aclk    (aclk),
            .en      (en),
            .bit_pos (IDX_W'(ROOT_W - 1 - i)),
            .d_in    (sq_q[i]),
            .d_out   (sq_q[i+1])
        );
    end

    // ---------------- atan2 setup: lane 0 latitude, lane 1 longitude
    vec_t       vec0_reg  [2];
    logic [1:0] zero_reg  [ITERS+1];
    vec_t       vec0_next [2];
    logic [1:0] zero_next;

    always_comb begin
        logic signed [VEC_W-1:0] ax [2];
        logic signed [VEC_W-1:0] ay [2];
        ax[0] = VEC_W'(signed'({1'b0, sq_q[ROOT_W].root}));
        ay[0] = VEC_W'(args_reg[ROOT_W].s);
        ax[1] = VEC_W'(args_reg[ROOT_W].den);
        ay[1] = VEC_W'(args_reg[ROOT_W].num);
        for (int l = 0; l < 2; l++) begin
            zero_next[l] = (ax[l] == '0) && (ay[l] == '0);
            if (ax[l][VEC_W-1]) begin
                vec0_next[l].x = -ax[l];
                vec0_next[l].y = -ay[l];
                vec0_next[l].z = 32'h8000_0000;
            end else begin
                vec0_next[l].x = ax[l];
                vec0_next[l].y = ay[l];
                vec0_next[l].z = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec0_reg    <= vec0_next;
            zero_reg[0] <= zero_next;
            for (int j = 1; j <= ITERS; j++) begin
                zero_reg[j] <= zero_reg[j-1];
            end
        end
    end

    // ---------------- atan2 cell rows
    vec_t vec_q [2][ITERS+1];

    for (genvar l = 0; l < 2; l++) begin : g_at
        assign vec_q[l][0] = vec0_reg[l];
        for (genvar i = 0; i < ITERS; i++) begin : g_cell
            fpos_vec_cell u_cell (
                .aclk  (aclk),
                .en    (en),
                .iter  (IDX_W'(i)),
                .d_in  (vec_q[l][i]),
                .d_out (vec_q[l][i+1])
            );
        end
    end

    angle_t           res_lat;
    angle_t           res_lon;
    logic [OUT_W-1:0] res_data;

    assign res_lat  = zero_reg[ITERS][0] ? '0 : vec_q[0][ITERS].z;
    assign res_lon  = zero_reg[ITERS][1] ? '0 : angle_t'(-vec_q[1][ITERS].z);
    assign res_data = {tag_reg[LAT-1], res_lat, res_lon};

    // ---------------- control: valid and tag lines, config, output and skid
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             out_free;
    logic             pipe_out;

    assign en       = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign pipe_out = en && valid_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int j = 0; j < LAT; j++) begin
                valid_reg[j] <= 1'b0;
            end
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (en) begin
                valid_reg[0] <= s_axis_tvalid;
                for (int j = 1; j < LAT; j++) begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
            if (out_free) begin
                out_valid_reg <= skid_valid_reg || pipe_out;
            end
            if (skid_valid_reg && out_free) begin
                skid_valid_reg <= 1'b0;
            end else if (pipe_out && !out_free) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= s_axis_tdata[4*ANGLE_W +: TAG_W];
            for (int j = 1; j < LAT; j++) begin
                tag_reg[j] <= tag_reg[j-1];
            end
        end
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
        end
        if (pipe_out && !out_free) begin
            skid_data_reg <= res_data;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

### src/fpos_checker.sv
// port-level checks on the focal-plane-to-sky block, bound to the top level
// depends on fpos_pkg and focal_plane_offset_to_sky_assert.svh
`default_nettype none

`include "focal_plane_offset_to_sky_assert.svh"

module fpos_checker
    import fpos_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    logic out_stall;
    logic in_blocked;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign in_blocked = !s_axis_tready;

    // a stalled result item holds
    `FPOS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata),
                      "result item changed while stalled")

    // input side only backs off after the output side stalled
    `FPOS_ASSERT_NOW(a_ready_cause, in_blocked, m_axis_tvalid && $past(out_stall),
                     "input not ready without an output stall")

    // a parked item drains as soon as the output takes one
    `FPOS_ASSERT_NEXT(a_skid_drain, in_blocked && m_axis_tready, s_axis_tready,
                      "input still blocked after output drained")

endmodule

bind focal_plane_offset_to_sky fpos_checker u_fpos_checker (.*);

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench for focal_plane_offset_to_sky: random and directed pointing items,
// a fixed-point cordic predictor, random stalls on both sides; depends on fpos_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
    import fpos_pkg::*;

    localparam longint TURN   = 64'sd1 << 32;
    localparam longint HALF   = 64'sd1 << 31;
    localparam longint QUART  = 64'sd1 << 30;
    localparam longint GAIN_Q = 64'sh26DD3B6A;
    localparam int     LIMIT  = 400000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // boresight_lon, boresight_lat, offset_x, offset_y, detector_tag
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // sky_lon, sky_lat, result_tag
    logic [OUT_W-1:0]  m_axis_tdata;

    logic [IN_W-1:0]   pend_q [$];
    logic [OUT_W-1:0]  sky_q [$];
    longint            atan_rom [ITERS];
    bit                frame_mode = 1'b1;
    bit                no_idle = 1'b0;
    int                errors = 0;
    int                cycles = 0;

    focal_plane_offset_to_sky u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // arctangent table from the alternating series, scaled by 1/(2 pi) in q64
    function automatic void build_atan_rom();
        longint unsigned r, term, t;
        logic [127:0]    prod;
        atan_rom[0] = 64'sd1 << 29;
        for (int i = 1; i < ITERS; i++) begin
            r = 0;
            for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
                term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
                if (k & 1) r = r - term;
                else r = r + term;
            end
            prod = 128'(r) * 128'(64'h28BE60DB9391054A);
            t = prod[127:64];
            t = (t + (64'd1 << 29)) >> 30;
            atan_rom[i] = longint'(t);
        end
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void rot_sincos(logic [31:0] ang, output longint s, output longint c);
        longint z, x, y, nx;
        bit     flip;
        x = GAIN_Q;
        y = 0;
        flip = 1'b0;
        z = ang[31] ? longint'({32'd0, ang}) - TURN : longint'({32'd0, ang});
        if (z > QUART || z < -QUART) begin
            z = (z > 0) ? z - HALF : z + HALF;
            flip = 1'b1;
        end
        for (int i = 0; i < ITERS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_rom[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_rom[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [31:0] vec_atan2(longint y, longint x);
        longint z, nx;
        z = 0;
        if (x == 0 && y == 0) return 32'd0;
        if (x < 0) begin
            x = -x; y = -y; z = HALF;
        end
        for (int i = 0; i < ITERS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_rom[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_rom[i];
            end
            x = nx;
        end
        return z[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b); r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sky_of_offset(logic [IN_W-1:0] d, bit eq_mode);
        longint sa, ca, sd, cd, sx, cx, sy, cy, cxcy, sxcy, s, c, num, den;
        longint unsigned sq;
        logic [31:0] lat, lon;
        rot_sincos(d[31:0],   sa, ca);
        rot_sincos(d[63:32],  sd, cd);
        rot_sincos(d[95:64],  sx, cx);
        rot_sincos(d[127:96], sy, cy);
        if (eq_mode) sy = -sy;
        cxcy = qmul(cx, cy);
        sxcy = qmul(sx, cy);
        s = qmul(sd, cxcy) + qmul(cd, sy);
        if (s > QUART) s = QUART;
        if (s < -QUART) s = -QUART;
        sq = longint'(s < 0 ? -s : s);
        c = longint'(int_sqrt((64'd1 << 60) - sq * sq));
        lat = vec_atan2(s, c);
        num = -qmul(qmul(sa, cd), cxcy) - qmul(ca, sxcy) + qmul(qmul(sa, sd), sy);
        den = qmul(qmul(ca, cd), cxcy) - qmul(sa, sxcy) - qmul(qmul(ca, sd), sy);
        lon = 32'd0 - vec_atan2(num, den);
        return {d[143:128], lat, lon};
    endfunction

    function automatic logic [31:0] pick_angle(bit inside_quarter);
        logic [31:0] specials [8] = '{32'h0, 32'h1, 32'h7FFFFFFF, 32'h80000000,
                                      32'h40000000, 32'hC0000000, 32'hFFFFFFFF, 32'h3FFFFFFF};
        int r;
        r = $urandom_range(99);
        if (r < 8) return specials[$urandom_range(7)];
        if (inside_quarter && r < 85) return $urandom_range(32'h7FFFFFFE) - 32'h3FFFFFFF;
        return $urandom;
    endfunction

    function automatic void add_pending(logic [IN_W-1:0] item);
        pend_q.insert(pend_q.size(), item);
    endfunction

    task automatic queue_random(int n);
        logic [31:0] a, b, x, y;
        for (int i = 0; i < n; i++) begin
            a = pick_angle(1'b0);
            b = pick_angle(1'b1);
            x = pick_angle(1'b1);
            y = pick_angle(1'b1);
            add_pending({16'($urandom), y, x, b, a});
        end
    endtask

    task automatic queue_directed();
        add_pending({16'h0000, 32'h0, 32'h0, 32'h0, 32'h0});
        add_pending({16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
        add_pending({16'h5A5A, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
        // y at plus and minus a quarter turn: cos(y) vanishes
        add_pending({16'h0001, 32'h40000000, 32'h01000000, 32'h10000000, 32'h20000000});
        add_pending({16'h0002, 32'hC0000000, 32'hF0000000, 32'hE0000000, 32'h30000000});
        // y beyond a quarter turn
        add_pending({16'h0003, 32'h50000000, 32'h00100000, 32'h08000000, 32'h12345678});
        add_pending({16'h0004, 32'hB0000000, 32'h00000000, 32'hF8000000, 32'h87654321});
        // boresight at the poles with zero offsets
        add_pending({16'h0005, 32'h0, 32'h0, 32'h40000000, 32'h0});
        add_pending({16'h0006, 32'h0, 32'h0, 32'hC0000000, 32'h0});
        add_pending({16'h0007, 32'h0, 32'h0, 32'h40000000, 32'h40000000});
        // latitude near the asin limit
        add_pending({16'h0008, 32'h40000000, 32'h0, 32'h0, 32'h0});
        add_pending({16'h0009, 32'h3FFFFFFF, 32'h00000001, 32'h3FFFFFFF, 32'h00000001});
        add_pending({16'hA5A5, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
        add_pending({16'h8000, 32'h00000001, 32'h80000001, 32'h00000001, 32'h80000001});
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || sky_q.size() != 0 || s_axis_tvalid) @(posedge aclk);
        repeat (LAT + 20) @(posedge aclk);
    endtask

    task automatic set_mode(bit m);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        frame_mode = m;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                sky_q.insert(sky_q.size(), sky_of_offset(s_axis_tdata, frame_mode));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pend_q.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pend_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (sky_q.size() == 0) begin
                    $error("result item with nothing expected: %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = sky_q.pop_front();
                    if (m_axis_tdata[31:0] !== want[31:0]) begin
                        $error("sky_lon expected %h actual %h", want[31:0], m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[63:32] !== want[63:32]) begin
                        $error("sky_lat expected %h actual %h", want[63:32], m_axis_tdata[63:32]);
                        errors++;
                    end
                    if (m_axis_tdata[79:64] !== want[79:64]) begin
                        $error("result_tag expected %h actual %h", want[79:64],
                               m_axis_tdata[79:64]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= no_idle || $urandom_range(99) >= 10;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[focal_plane_offset_to_sky] ERROR");
            $finish;
        end
    end

    initial begin
        build_atan_rom();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting is equatorial
        queue_directed();
        drain();
        set_mode(1'b0);
        queue_directed();
        queue_random(280);
        drain();
        set_mode(1'b1);
        no_idle = 1'b1;
        queue_random(150);
        while (pend_q.size() != 0) @(posedge aclk);
        no_idle = 1'b0;
        queue_random(150);
        drain();
        set_mode(1'b0);
        queue_random(200);
        drain();

        if (errors == 0 && sky_q.size() == 0) begin
            $display("[focal_plane_offset_to_sky] OK");
        end else begin
            $display("[focal_plane_offset_to_sky] ERROR");
        end
        $finish;
    end

endmodule
